[rtl/kse_pkg.sv]
// Shared types, constants and helper functions of the keypad scan event encoder.
package kse_pkg;

  // Operation codes of an input item.
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes.
  localparam logic REG_BOARD_VERSION = 1'b0;
  localparam logic REG_KEY_LOCK      = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_EVENT  = 2'd0;
  localparam logic [1:0] KIND_SYNC   = 2'd1;
  localparam logic [1:0] KIND_HOTKEY = 2'd2;

  // Hotkey codes.
  localparam logic [2:0] HK_NONE      = 3'd0;
  localparam logic [2:0] HK_BKL_UP    = 3'd1;
  localparam logic [2:0] HK_BKL_DOWN  = 3'd2;
  localparam logic [2:0] HK_VOL_UP    = 3'd3;
  localparam logic [2:0] HK_VOL_DOWN  = 3'd4;

  // Board versions that matter to the decode.
  localparam logic [2:0] VER_ONE      = 3'd1;
  localparam logic [2:0] VER_TWO      = 3'd2;
  localparam logic [2:0] VER_THREE    = 3'd3;

  // Button word bits.
  localparam logic [15:0] B_TB     = 16'h0002;
  localparam logic [15:0] B_MENU   = 16'h0004;
  localparam logic [15:0] B_UP     = 16'h0008;
  localparam logic [15:0] B_TA     = 16'h0010;
  localparam logic [15:0] B_B      = 16'h0020;
  localparam logic [15:0] B_RIGHT  = 16'h0040;
  localparam logic [15:0] B_LEFT   = 16'h0080;
  localparam logic [15:0] B_A      = 16'h0100;
  localparam logic [15:0] B_START  = 16'h0200;
  localparam logic [15:0] B_SELECT = 16'h0400;
  localparam logic [15:0] B_DOWN   = 16'h0800;
  localparam logic [15:0] B_L1     = 16'h1000;
  localparam logic [15:0] B_R1     = 16'h2000;
  localparam logic [15:0] B_L2     = 16'h4000;
  localparam logic [15:0] B_R2     = 16'h8000;

  // Number of key codes, one per position in the report order.
  localparam int NUM_KEYS = 15;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        operation;
    logic [3:0]  row0_columns;
    logic [3:0]  row1_columns;
    logic [3:0]  row2_columns;
    logic [13:0] direct_levels;
  } kse_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] key_code;
    logic       pressed;
    logic [2:0] hotkey_value;
    logic       last;
  } kse_out_t;

  // One job for the back end: a hotkey readout or a report of changed keys.
  typedef struct packed {
    logic                is_read;
    logic [2:0]          hotkey;
    logic [NUM_KEYS-1:0] chg;
    logic [NUM_KEYS-1:0] val;
  } kse_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kse_q_status_t;

  // Picks the button word bits in report order; swap exchanges left and menu.
  function automatic logic [NUM_KEYS-1:0] order_bits(input logic [15:0] w,
                                                     input logic swap);
    logic [NUM_KEYS-1:0] o;
    o[0]  = |(w & B_UP);
    o[1]  = |(w & B_DOWN);
    o[2]  = swap ? |(w & B_MENU) : |(w & B_LEFT);
    o[3]  = swap ? |(w & B_LEFT) : |(w & B_MENU);
    o[4]  = |(w & B_RIGHT);
    o[5]  = |(w & B_A);
    o[6]  = |(w & B_B);
    o[7]  = |(w & B_TA);
    o[8]  = |(w & B_TB);
    o[9]  = |(w & B_SELECT);
    o[10] = |(w & B_START);
    o[11] = |(w & B_L1);
    o[12] = |(w & B_R1);
    o[13] = |(w & B_L2);
    o[14] = |(w & B_R2);
    return o;
  endfunction

  function automatic logic all_set(input logic [15:0] v, input logic [15:0] m);
    return (v & m) == m;
  endfunction

endpackage

[rtl/kse_front.sv]
// Front end: configuration, button word decode, filters and the reported state.
module kse_front
  import kse_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kse_in_t       in_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [2:0]    cfg_data,
  input  kse_q_status_t q_stat,
  output logic          push,
  output kse_job_t      push_job
);

  logic [2:0]  board_version_r, board_version_nxt;
  logic        key_lock_r, key_lock_nxt;
  logic [15:0] reported_r, reported_nxt;
  logic [2:0]  hotkey_r, hotkey_nxt;

  logic        accept;
  logic        swap;
  logic [15:0] d;
  logic [15:0] raw;
  logic [15:0] locked;
  logic [15:0] ghost;
  logic [15:0] hk_word;
  logic [15:0] word;
  logic [2:0]  hk_new;
  logic [4:0]  pop;
  logic        changed;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_stat.full;
  assign accept    = in_valid && in_ready;
  assign swap      = !(board_version_r == VER_ONE || board_version_r == VER_THREE);

  // Button word from the pin samples, by pin map.
  always_comb begin
    d   = {2'b00, ~in_data.direct_levels};
    raw = '0;
    if (board_version_r <= VER_TWO) begin
      raw[3:0]  = ~in_data.row0_columns;
      raw[7:4]  = ~in_data.row1_columns;
      raw[11:8] = ~in_data.row2_columns;
      if (d[9])  raw = raw | B_L1;
      if (d[10]) raw = raw | B_R1;
      if (d[11]) raw = raw | B_B;
      if (d[12]) raw = raw | B_TB;
      if (d[7])  raw = raw | B_A;
      if (d[8])  raw = raw | B_TA;
    end else begin
      if (d[0])  raw = raw | B_UP;
      if (d[1])  raw = raw | B_DOWN;
      if (d[2])  raw = raw | B_LEFT;
      if (d[3])  raw = raw | B_RIGHT;
      if (d[4])  raw = raw | B_A;
      if (d[5])  raw = raw | B_B;
      if (d[6])  raw = raw | B_TA;
      if (d[8])  raw = raw | B_TB;
      if (d[7])  raw = raw | B_SELECT;
      if (d[11]) raw = raw | B_START;
      if (d[9])  raw = raw | B_L1;
      if (d[10]) raw = raw | B_R1;
      if (d[13]) raw = raw | B_MENU;
    end
  end

  // Key lock keeps only the menu button.
  assign locked = key_lock_r ? (raw & B_MENU) : raw;

  // Ghost suppression when more than two buttons read as down.
  always_comb begin
    pop = '0;
    for (int i = 0; i < 16; i++) begin
      pop = pop + {4'd0, locked[i]};
    end
    ghost = locked;
    if (pop > 5'd2) begin
      if (all_set(ghost, B_LEFT | B_DOWN | B_B)) ghost = ghost & ~B_START;
      if (all_set(ghost, B_LEFT | B_A | B_TA))   ghost = ghost & ~B_DOWN;
      if (all_set(ghost, B_LEFT | B_DOWN | B_A)) ghost = ghost & ~B_TA;
      if (all_set(ghost, B_LEFT | B_UP | B_B))   ghost = ghost & ~B_TA;
      if (all_set(ghost, B_B | B_A | B_TA))      ghost = ghost & ~B_START;
      if (all_set(ghost, B_RIGHT | B_UP | B_B | B_TB | B_TA)) ghost = ghost & ~B_START;
    end
  end

  // Select hotkeys: the first matching combination wins and its partner drops out.
  always_comb begin
    hk_word = ghost;
    hk_new  = HK_NONE;
    priority if (all_set(ghost, B_SELECT | B_B)) begin
      hk_new  = HK_VOL_UP;
      hk_word = ghost & ~B_B;
    end else if (all_set(ghost, B_SELECT | B_A)) begin
      hk_new  = HK_VOL_DOWN;
      hk_word = ghost & ~B_A;
    end else if (all_set(ghost, B_SELECT | B_TB)) begin
      hk_new  = HK_BKL_UP;
      hk_word = ghost & ~B_TB;
    end else if (all_set(ghost, B_SELECT | B_TA)) begin
      hk_new  = HK_BKL_DOWN;
      hk_word = ghost & ~B_TA;
    end else begin
      hk_new  = HK_NONE;
    end
  end

  // Start combinations turn into shoulder buttons.
  always_comb begin
    word = hk_word;
    priority if (all_set(hk_word, B_START | B_B)) begin
      word = (hk_word & ~(B_B | B_START)) | B_L1;
    end else if (all_set(hk_word, B_START | B_A)) begin
      word = (hk_word & ~(B_A | B_START)) | B_R1;
    end else if (all_set(hk_word, B_START | B_TB)) begin
      word = (hk_word & ~(B_TB | B_START)) | B_L2;
    end else if (all_set(hk_word, B_START | B_TA)) begin
      word = (hk_word & ~(B_TA | B_START)) | B_R2;
    end else begin
      word = hk_word;
    end
  end

  assign changed = word != reported_r;

  // Job for the back end.
  always_comb begin
    push_job.is_read = in_data.operation == OP_READ;
    push_job.hotkey  = hotkey_r;
    push_job.chg     = order_bits(word ^ reported_r, swap);
    push_job.val     = order_bits(word, swap);
    push = accept && (in_data.operation == OP_READ || changed);
  end

  // Next state of registers and reported state.
  always_comb begin
    board_version_nxt = board_version_r;
    key_lock_nxt      = key_lock_r;
    reported_nxt      = reported_r;
    hotkey_nxt        = hotkey_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOARD_VERSION: board_version_nxt = (cfg_data == 3'd0) ? VER_ONE : cfg_data;
        REG_KEY_LOCK:      key_lock_nxt      = cfg_data[0];
        default:           board_version_nxt = board_version_r;
      endcase
    end
    if (accept) begin
      if (in_data.operation == OP_READ) begin
        hotkey_nxt = HK_NONE;
      end else begin
        if (hotkey_r == HK_NONE) hotkey_nxt = hk_new;
        reported_nxt = word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_version_r <= VER_ONE;
      key_lock_r      <= 1'b0;
      reported_r      <= '0;
      hotkey_r        <= HK_NONE;
    end else begin
      board_version_r <= board_version_nxt;
      key_lock_r      <= key_lock_nxt;
      reported_r      <= reported_nxt;
      hotkey_r        <= hotkey_nxt;
    end
  end

endmodule

[rtl/kse_queue.sv]
// Short job queue that decouples the front end from the event back end.
module kse_queue
  import kse_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  kse_job_t      push_job,
  input  logic          pop,
  output kse_job_t      pop_job,
  output kse_q_status_t q_stat
);

  kse_job_t          entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = cnt_r == QCNT_W'(QDEPTH);
  assign q_stat.empty = cnt_r == '0;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_job      = entries_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/kse_back.sv]
// Back end: walks one job and emits its result items, one per cycle while the output is not stalled.
module kse_back
  import kse_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  kse_q_status_t q_stat,
  input  kse_job_t      pop_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output kse_out_t      out_data
);

  logic                cur_valid_r, cur_valid_nxt;
  logic                cur_read_r;
  logic [2:0]          cur_hk_r;
  logic [NUM_KEYS-1:0] cur_rem_r, cur_rem_nxt;
  logic [NUM_KEYS-1:0] cur_val_r;
  logic                out_valid_r, out_valid_nxt;
  kse_out_t            out_data_r;
  kse_out_t            item;
  logic                item_last;
  logic                step;
  logic [3:0]          idx;

  // First remaining changed key in report order.
  always_comb begin
    idx = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (cur_rem_r[i]) idx = 4'(i);
    end
  end

  // Item for the current position of the job.
  always_comb begin
    item = '0;
    if (cur_read_r) begin
      item.kind         = KIND_HOTKEY;
      item.hotkey_value = cur_hk_r;
      item.last         = 1'b1;
    end else if (cur_rem_r != '0) begin
      item.kind     = KIND_EVENT;
      item.key_code = idx;
      item.pressed  = cur_val_r[idx];
    end else begin
      item.kind = KIND_SYNC;
      item.last = 1'b1;
    end
    item_last = item.last;
  end

  assign step = cur_valid_r && (!out_valid_r || out_ready);
  assign pop  = !q_stat.empty && (!cur_valid_r || (step && item_last));

  // Job register control.
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_rem_nxt   = cur_rem_r;
    if (step) begin
      cur_rem_nxt = cur_rem_r & (cur_rem_r - 1'b1);
      if (item_last) cur_valid_nxt = 1'b0;
    end
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_rem_nxt   = pop_job.chg;
    end
    out_valid_nxt = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_rem_r <= cur_rem_nxt;
    if (pop) begin
      cur_read_r <= pop_job.is_read;
      cur_hk_r   <= pop_job.hotkey;
      cur_val_r  <= pop_job.val;
    end
    if (step) begin
      out_data_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/keypad_scan_event_encoder.sv]
// Top level of the keypad scan event encoder: front end, job queue and event back end.
//
//   Channel   Ports                                   Direction
//   in        in_valid, in_ready, in_data             item in
//   out       out_valid, out_ready, out_data          item out
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data   register write
//
// An input item is decoded and classified in the cycle it is accepted.
// A scan that changes N keys gives N + 1 result items, a read gives one;
// the back end emits one item per cycle while out_ready holds, so its walk sets the sustained rate.
// A scan that changes nothing gives no item.
// Synchronous active-low reset sets board version one and clears key lock, reported buttons and hotkey.
// A stalled output holds its item while the two-entry queue keeps taking items until it is full.
module keypad_scan_event_encoder
  import kse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  kse_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output kse_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data
);

  kse_q_status_t q_stat;
  kse_job_t      push_job;
  kse_job_t      pop_job;
  logic          push;
  logic          pop;

  kse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  kse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  kse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The queue is never full and empty at once.
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // Syncs and readouts always close their input's results.
  a_closing_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_SYNC || out_data.kind == KIND_HOTKEY)
    |-> out_data.last)
    else $error("closing item without last");

  // Key events are never last and carry no hotkey.
  a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_EVENT
    |-> !out_data.last && out_data.hotkey_value == HK_NONE)
    else $error("key event with bad fields");

  // A push is only made when the queue has room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into a full queue");

endmodule

[tb/sv/keypad_scan_event_encoder_test.sv]
// Self-checking testbench for the keypad scan event encoder: predicted key reports vs DUT.
module keypad_scan_event_encoder_test;
  import kse_pkg::*;

  // Button bits in the order the block reports changes, key code = position.
  localparam logic [15:0] REPORT_ORDER [NUM_KEYS] = '{
    B_UP, B_DOWN, B_LEFT, B_MENU, B_RIGHT, B_A, B_B, B_TA, B_TB,
    B_SELECT, B_START, B_L1, B_R1, B_L2, B_R2
  };

  // Button groups that trigger ghost suppression, hotkeys and shoulder remaps.
  localparam logic [15:0] COMBOS [14] = '{
    B_LEFT | B_DOWN | B_B, B_LEFT | B_A | B_TA, B_LEFT | B_DOWN | B_A,
    B_LEFT | B_UP | B_B, B_B | B_A | B_TA, B_RIGHT | B_UP | B_B | B_TB | B_TA,
    B_SELECT | B_B, B_SELECT | B_A, B_SELECT | B_TB, B_SELECT | B_TA,
    B_START | B_B, B_START | B_A, B_START | B_TB, B_START | B_TA
  };

  // Register settings per random phase; the last flag turns idling off.
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 23;
  localparam logic [2:0] PHASE_VER [NUM_PHASES] = '{2, 3, 4, 0, 7, 5, 3, 6, 1};
  localparam logic PHASE_LOCK [NUM_PHASES] = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
  localparam logic PHASE_STEADY [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0, 0, 0};

  // Keeps a copy of the block's registers and state and the events still awaited.
  class key_report_board;
    logic [2:0]  version;
    logic        lock;
    logic [15:0] shown;
    logic [2:0]  hotkey;
    kse_out_t    awaited_events[$];
    int          faults;

    function new();
      version = VER_ONE;
      lock = 1'b0;
      shown = '0;
      hotkey = HK_NONE;
      faults = 0;
    endfunction

    function int pending();
      return awaited_events.size();
    endfunction

    function void note_config(logic idx, logic [2:0] val);
      if (idx == REG_BOARD_VERSION) begin
        version = (val == 3'd0) ? VER_ONE : val;
      end else begin
        lock = val[0];
      end
    endfunction

    function bit holds(logic [15:0] w, logic [15:0] m);
      return (w & m) == m;
    endfunction

    // Works out the events that one accepted item causes.
    function void note_input(kse_in_t it);
      logic [15:0] w;
      logic [15:0] chg;
      logic [15:0] m;
      logic [13:0] d;
      logic        swap;
      kse_out_t    r;
      r = '0;
      if (it.operation == OP_READ) begin
        r.kind = KIND_HOTKEY;
        r.hotkey_value = hotkey;
        r.last = 1'b1;
        awaited_events.push_back(r);
        hotkey = HK_NONE;
        return;
      end
      // Button word from the pins of this board.
      d = ~it.direct_levels;
      w = '0;
      if (version <= VER_TWO) begin
        w[11:0] = ~{it.row2_columns, it.row1_columns, it.row0_columns};
        if (d[9])  w |= B_L1;
        if (d[10]) w |= B_R1;
        if (d[11]) w |= B_B;
        if (d[12]) w |= B_TB;
        if (d[7])  w |= B_A;
        if (d[8])  w |= B_TA;
      end else begin
        if (d[0])  w |= B_UP;
        if (d[1])  w |= B_DOWN;
        if (d[2])  w |= B_LEFT;
        if (d[3])  w |= B_RIGHT;
        if (d[4])  w |= B_A;
        if (d[5])  w |= B_B;
        if (d[6])  w |= B_TA;
        if (d[8])  w |= B_TB;
        if (d[7])  w |= B_SELECT;
        if (d[11]) w |= B_START;
        if (d[9])  w |= B_L1;
        if (d[10]) w |= B_R1;
        if (d[13]) w |= B_MENU;
      end
      if (lock) w = |(w & B_MENU) ? B_MENU : 16'h0000;
      // Ghost suppression only applies with three or more buttons down.
      if ($countones(w) > 2) begin
        if (holds(w, B_LEFT | B_DOWN | B_B)) w &= ~B_START;
        if (holds(w, B_LEFT | B_A | B_TA)) w &= ~B_DOWN;
        if (holds(w, B_LEFT | B_DOWN | B_A)) w &= ~B_TA;
        if (holds(w, B_LEFT | B_UP | B_B)) w &= ~B_TA;
        if (holds(w, B_B | B_A | B_TA)) w &= ~B_START;
        if (holds(w, B_RIGHT | B_UP | B_B | B_TB | B_TA)) w &= ~B_START;
      end
      // Select hotkeys: the first one sticks, the partner button always drops.
      if (holds(w, B_SELECT | B_B)) begin
        if (hotkey == HK_NONE) hotkey = HK_VOL_UP;
        w &= ~B_B;
      end else if (holds(w, B_SELECT | B_A)) begin
        if (hotkey == HK_NONE) hotkey = HK_VOL_DOWN;
        w &= ~B_A;
      end else if (holds(w, B_SELECT | B_TB)) begin
        if (hotkey == HK_NONE) hotkey = HK_BKL_UP;
        w &= ~B_TB;
      end else if (holds(w, B_SELECT | B_TA)) begin
        if (hotkey == HK_NONE) hotkey = HK_BKL_DOWN;
        w &= ~B_TA;
      end
      // Start combinations become shoulder buttons.
      if (holds(w, B_START | B_B)) begin
        w = (w & ~(B_B | B_START)) | B_L1;
      end else if (holds(w, B_START | B_A)) begin
        w = (w & ~(B_A | B_START)) | B_R1;
      end else if (holds(w, B_START | B_TB)) begin
        w = (w & ~(B_TB | B_START)) | B_L2;
      end else if (holds(w, B_START | B_TA)) begin
        w = (w & ~(B_TA | B_START)) | B_R2;
      end
      if (w == shown) return;
      chg = w ^ shown;
      shown = w;
      swap = !(version == VER_ONE || version == VER_THREE);
      // One event per changed key in report order, then the sync.
      for (int i = 0; i < NUM_KEYS; i++) begin
        m = REPORT_ORDER[i];
        if (swap && i == 2) m = B_MENU;
        else if (swap && i == 3) m = B_LEFT;
        if (|(chg & m)) begin
          r = '0;
          r.kind = KIND_EVENT;
          r.key_code = 4'(i);
          r.pressed = |(w & m);
          awaited_events.push_back(r);
        end
      end
      r = '0;
      r.kind = KIND_SYNC;
      r.last = 1'b1;
      awaited_events.push_back(r);
    endfunction

    function void field_ok(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        faults++;
      end
    endfunction

    // Compares one result item with the oldest awaited event.
    function void check_result(kse_out_t got);
      kse_out_t want;
      if (awaited_events.size() == 0) begin
        $error("unexpected result item: kind %0d key_code %0d", got.kind, got.key_code);
        faults++;
        return;
      end
      want = awaited_events.pop_front();
      field_ok("kind", want.kind, got.kind);
      field_ok("key_code", want.key_code, got.key_code);
      field_ok("pressed", want.pressed, got.pressed);
      field_ok("hotkey_value", want.hotkey_value, got.hotkey_value);
      field_ok("last", want.last, got.last);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  kse_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  kse_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [2:0] cfg_data;
  bit         steady;
  kse_in_t    last_scan;

  key_report_board board = new();

  keypad_scan_event_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle length: mostly none, some short, a few long; none in steady phases.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side stalls at random.
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  // Pin levels that press the given buttons on the current board; unused pins are noise.
  function automatic kse_in_t pins_for(logic [15:0] w);
    kse_in_t it;
    it = kse_in_t'($urandom);
    it.operation = OP_SCAN;
    if (board.version <= VER_TWO) begin
      {it.row2_columns, it.row1_columns, it.row0_columns} = ~w[11:0];
      it.direct_levels[7]  = ~|(w & B_A);
      it.direct_levels[8]  = ~|(w & B_TA);
      it.direct_levels[9]  = ~|(w & B_L1);
      it.direct_levels[10] = ~|(w & B_R1);
      it.direct_levels[11] = ~|(w & B_B);
      it.direct_levels[12] = ~|(w & B_TB);
    end else begin
      it.direct_levels[0]  = ~|(w & B_UP);
      it.direct_levels[1]  = ~|(w & B_DOWN);
      it.direct_levels[2]  = ~|(w & B_LEFT);
      it.direct_levels[3]  = ~|(w & B_RIGHT);
      it.direct_levels[4]  = ~|(w & B_A);
      it.direct_levels[5]  = ~|(w & B_B);
      it.direct_levels[6]  = ~|(w & B_TA);
      it.direct_levels[7]  = ~|(w & B_SELECT);
      it.direct_levels[8]  = ~|(w & B_TB);
      it.direct_levels[9]  = ~|(w & B_L1);
      it.direct_levels[10] = ~|(w & B_R1);
      it.direct_levels[11] = ~|(w & B_START);
      it.direct_levels[13] = ~|(w & B_MENU);
    end
    return it;
  endfunction

  function automatic kse_in_t read_item();
    kse_in_t it;
    it = kse_in_t'($urandom);
    it.operation = OP_READ;
    return it;
  endfunction

  // Offers one item after a random gap and holds it until accepted.
  task automatic send_item(kse_in_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    board.note_input(it);
    if (it.operation == OP_SCAN) last_scan = it;
  endtask

  // Stops sending and waits until every awaited event has come, then settles.
  task automatic drain(int settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [2:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    board.note_config(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold-off for the run as a whole.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int r;
    kse_in_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_BOARD_VERSION;
    cfg_data = '0;
    steady = 1'b0;
    last_scan = '1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed items on the reset settings.
    send_item(read_item());
    send_item('1 & ~kse_in_t'(1 << $bits(kse_in_t) - 1));
    send_item('0);
    send_item('0);
    send_item(pins_for(16'h0000));
    send_item(pins_for(16'h0001));
    send_item(pins_for(B_SELECT | B_B));
    send_item(pins_for(B_SELECT | B_A));
    send_item(read_item());
    send_item('1);
    send_item(pins_for(B_SELECT | B_TB));
    send_item(read_item());
    send_item(pins_for(B_SELECT | B_TA));
    send_item(read_item());
    send_item(pins_for(B_START | B_B));
    send_item(pins_for(B_START | B_A));
    send_item(pins_for(B_START | B_TB));
    send_item(pins_for(B_START | B_TA));
    send_item(pins_for(B_LEFT | B_DOWN | B_B | B_START));
    send_item(pins_for(B_LEFT | B_A | B_TA | B_DOWN));
    send_item(pins_for(B_LEFT | B_DOWN | B_A | B_TA));
    send_item(pins_for(B_LEFT | B_UP | B_B | B_TA));
    send_item(pins_for(B_B | B_A | B_TA | B_START));
    send_item(pins_for(B_RIGHT | B_UP | B_B | B_TB | B_TA | B_START));
    send_item(pins_for(16'h0000));

    // Random phases, each on its own register settings.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain(4);
      steady = PHASE_STEADY[p];
      write_reg(REG_BOARD_VERSION, PHASE_VER[p]);
      write_reg(REG_KEY_LOCK, {2'($urandom), PHASE_LOCK[p]});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 3) drain(0);
        r = $urandom_range(0, 99);
        if (r < 10) it = read_item();
        else if (r < 22) it = last_scan;
        else if (r < 32) it = kse_in_t'({$urandom, $urandom}) & ~kse_in_t'(1 << 26);
        else if (r < 37) it = pins_for(16'h0000);
        else if (r < 70) it = pins_for(COMBOS[$urandom_range(0, 13)] |
                                       16'($urandom & $urandom & $urandom));
        else it = pins_for(16'($urandom & $urandom & $urandom));
        send_item(it);
      end
    end

    // Let the last events come and watch for strays.
    drain(20);
    if (board.faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/kse_pkg.sv
rtl/kse_front.sv
rtl/kse_queue.sv
rtl/kse_back.sv
rtl/keypad_scan_event_encoder.sv
tb/sv/keypad_scan_event_encoder_test.sv
